// ----- src/kme_pkg.sv -----
// ----------------------------------------------------------------------------
// kme_pkg: shared types and constants of the key matrix emulator
// Holds the event codes, the matrix geometry and the host code to key table.
// ----------------------------------------------------------------------------
package kme_pkg;

  // Matrix geometry.
  localparam int unsigned NumRows   = 8;
  localparam int unsigned RowWidth  = 5;
  localparam int unsigned RowIdxW   = 3;

  // Event codes carried in the action field.
  localparam logic [1:0] ACT_PRESS   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_READ    = 2'd2;

  // Shift key position.
  localparam logic [RowIdxW-1:0]  SHIFT_ROW  = 3'd0;
  localparam logic [RowWidth-1:0] SHIFT_MASK = 5'h01;

  // Released row and the fill for rows beyond the matrix.
  localparam logic [RowWidth-1:0] ROW_RELEASED = 5'h1F;
  localparam logic [7:0]          ROW_NONE     = 8'hFF;
  localparam logic [2:0]          ROW_PAD      = 3'b111;

  typedef logic [RowWidth-1:0] row_t;

  // One decoded key.
  typedef struct packed {
    logic                known;
    logic [RowIdxW-1:0]  row;
    row_t                mask;
    logic                shifted;
  } key_entry_t;

  function automatic key_entry_t mk(input logic [RowIdxW-1:0] row, input row_t mask,
                                    input logic shifted);
    key_entry_t e;
    e.known   = 1'b1;
    e.row     = row;
    e.mask    = mask;
    e.shifted = shifted;
    return e;
  endfunction

  // Host character code to matrix position.
  function automatic key_entry_t key_lookup(input logic [7:0] code);
    key_entry_t e;
    e = '0;
    case (code)
      8'd49: e = mk(3'd3, 5'h01, 1'b0);
      8'd50: e = mk(3'd3, 5'h02, 1'b0);
      8'd51: e = mk(3'd3, 5'h04, 1'b0);
      8'd52: e = mk(3'd3, 5'h08, 1'b0);
      8'd53: e = mk(3'd3, 5'h10, 1'b0);
      8'd54: e = mk(3'd4, 5'h10, 1'b0);
      8'd55: e = mk(3'd4, 5'h08, 1'b0);
      8'd56: e = mk(3'd4, 5'h04, 1'b0);
      8'd57: e = mk(3'd4, 5'h02, 1'b0);
      8'd48: e = mk(3'd4, 5'h01, 1'b0);
      8'd65: e = mk(3'd1, 5'h01, 1'b0);
      8'd66: e = mk(3'd7, 5'h10, 1'b0);
      8'd67: e = mk(3'd0, 5'h08, 1'b0);
      8'd68: e = mk(3'd1, 5'h04, 1'b0);
      8'd69: e = mk(3'd2, 5'h04, 1'b0);
      8'd70: e = mk(3'd1, 5'h08, 1'b0);
      8'd71: e = mk(3'd1, 5'h10, 1'b0);
      8'd72: e = mk(3'd6, 5'h10, 1'b0);
      8'd73: e = mk(3'd5, 5'h04, 1'b0);
      8'd74: e = mk(3'd6, 5'h08, 1'b0);
      8'd75: e = mk(3'd6, 5'h04, 1'b0);
      8'd76: e = mk(3'd6, 5'h02, 1'b0);
      8'd77: e = mk(3'd7, 5'h04, 1'b0);
      8'd78: e = mk(3'd7, 5'h08, 1'b0);
      8'd79: e = mk(3'd5, 5'h02, 1'b0);
      8'd80: e = mk(3'd5, 5'h01, 1'b0);
      8'd81: e = mk(3'd2, 5'h01, 1'b0);
      8'd82: e = mk(3'd2, 5'h08, 1'b0);
      8'd83: e = mk(3'd1, 5'h02, 1'b0);
      8'd84: e = mk(3'd2, 5'h10, 1'b0);
      8'd85: e = mk(3'd5, 5'h08, 1'b0);
      8'd86: e = mk(3'd0, 5'h10, 1'b0);
      8'd87: e = mk(3'd2, 5'h02, 1'b0);
      8'd88: e = mk(3'd0, 5'h04, 1'b0);
      8'd89: e = mk(3'd5, 5'h10, 1'b0);
      8'd90: e = mk(3'd0, 5'h02, 1'b0);
      8'd32: e = mk(3'd7, 5'h01, 1'b0);
      8'd13: e = mk(3'd6, 5'h01, 1'b0);
      // Punctuation that needs shift held together with its key.
      8'd44: e = mk(3'd7, 5'h02, 1'b1);
      8'd59: e = mk(3'd0, 5'h04, 1'b1);
      8'd45: e = mk(3'd6, 5'h08, 1'b1);
      8'd61: e = mk(3'd6, 5'h02, 1'b1);
      8'd47: e = mk(3'd0, 5'h10, 1'b1);
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

// ----- src/kme_in_if.sv -----
// ----------------------------------------------------------------------------
// kme_in_if: key event channel
// Carries one press, release or row read word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface kme_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] keycode;
  logic [3:0] row_select;

  modport source (output valid, output action, output keycode, output row_select,
                  input ready);
  modport sink (input valid, input action, input keycode, input row_select,
                output ready);
endinterface

// ----- src/kme_out_if.sv -----
// ----------------------------------------------------------------------------
// kme_out_if: row result channel
// Carries the selected matrix row and the key lookup flag.
// ----------------------------------------------------------------------------
interface kme_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] row_bits;
  logic       key_known;

  modport source (output valid, output row_bits, output key_known, input ready);
  modport sink (input valid, input row_bits, input key_known, output ready);
endinterface

// ----- src/keyboard_matrix_emulator.sv -----
// ----------------------------------------------------------------------------
// keyboard_matrix_emulator: host key events to an active-low key matrix
// Keeps an 8 by 5 matrix, applies press and release words and returns rows.
// ----------------------------------------------------------------------------
// Usage:
//   evt_i takes one word per handshake: a press, a release or a row read.
//   A press clears the key's bit in the matrix, a release sets it again;
//   five punctuation codes move the shift key along with their own key.
//   res_o returns one word for every event word: the selected row after
//   that word's update, upper three bits high, and a flag that tells
//   whether the host code was found in the key table. Rows 8 to 15 read
//   as all ones.
//   The result is registered: an accepted word sits in the event register,
//   and the table lookup, matrix update and row read land in the result
//   register once it is free or drained. Throughput is one word per cycle
//   while res_o does not stall; the matrix register is the only loop.
//   When res_o stalls, a held result and a held event word fill both
//   stages before evt_i drops ready; an empty event stage still accepts.
//   Reset releases every key and empties both stages.
// ----------------------------------------------------------------------------
module keyboard_matrix_emulator
  import kme_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  kme_in_if.sink   evt_i,
  kme_out_if.source res_o
);

  // Event register.
  logic       evt_vld_q;
  logic [1:0] act_q;
  logic [7:0] code_q;
  logic [3:0] sel_q;

  // Matrix state and result register.
  row_t       matrix_q [NumRows];
  row_t       matrix_d [NumRows];
  logic       res_vld_q;
  logic [7:0] bits_q, bits_d;
  logic       known_q, known_d;

  logic       advance;
  key_entry_t ent;
  logic       is_key;
  logic       down;

  // The event stage moves on when the result register is free or drained.
  assign advance     = ~res_vld_q | res_o.ready;
  assign evt_i.ready = ~evt_vld_q | advance;

  // Capture the event word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_vld_q <= 1'b0;
    end else if (evt_i.ready) begin
      evt_vld_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.ready && evt_i.valid) begin
      act_q  <= evt_i.action;
      code_q <= evt_i.keycode;
      sel_q  <= evt_i.row_select;
    end
  end

  // Look up the key and work out the updated matrix.
  always_comb begin
    ent    = key_lookup(code_q);
    is_key = ((act_q == ACT_PRESS) || (act_q == ACT_RELEASE)) && ent.known;
    down   = (act_q == ACT_PRESS);
    for (int r = 0; r < NumRows; r++) begin
      matrix_d[r] = matrix_q[r];
      if (is_key && ent.shifted && (RowIdxW'(r) == SHIFT_ROW)) begin
        matrix_d[r] = down ? (matrix_d[r] & ~SHIFT_MASK) : (matrix_d[r] | SHIFT_MASK);
      end
      if (is_key && (RowIdxW'(r) == ent.row)) begin
        matrix_d[r] = down ? (matrix_d[r] & ~ent.mask) : (matrix_d[r] | ent.mask);
      end
    end
  end

  // Read the selected row after the update; the read code changes nothing.
  always_comb begin
    if (sel_q[3]) begin
      bits_d = ROW_NONE;
    end else begin
      bits_d = {ROW_PAD, matrix_d[sel_q[RowIdxW-1:0]]};
    end
    known_d = is_key;
  end

  // Matrix state; only a consumed event word commits its update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumRows; r++) begin
        matrix_q[r] <= ROW_RELEASED;
      end
    end else if (evt_vld_q && advance) begin
      for (int r = 0; r < NumRows; r++) begin
        matrix_q[r] <= matrix_d[r];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= evt_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_vld_q && advance) begin
      bits_q  <= bits_d;
      known_q <= known_d;
    end
  end

  assign res_o.valid     = res_vld_q;
  assign res_o.row_bits  = bits_q;
  assign res_o.key_known = known_q;

endmodule

// ----- tb/sv/tb_keyboard_matrix_emulator.sv -----
// ----------------------------------------------------------------------------
// tb_keyboard_matrix_emulator: self-checking bench for the key matrix emulator
// Sends press, release and row read words and keeps its own copy of the
// active-low key matrix. Each returned row word is checked field by field
// against that copy. Both channels see random gaps, and one long output stall
// fills the block. A directed opening covers the shifted punctuation keys,
// unknown codes, the unused action and rows beyond the matrix.
// ----------------------------------------------------------------------------
module tb_keyboard_matrix_emulator;
  import kme_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The action code that the block treats like a read.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int unsigned StallCycles = 80;
  localparam int unsigned StallAfter  = 250;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxPrints   = 20;

  typedef struct {
    logic [1:0] action;
    logic [7:0] keycode;
    logic [3:0] row_select;
  } key_word_t;

  typedef struct {
    logic [7:0] row_bits;
    logic       key_known;
  } row_word_t;

  // Where one host code lands in the matrix.
  typedef struct packed {
    logic               hit;
    logic               with_shift;
    logic [RowIdxW-1:0] row;
    row_t               mask;
  } key_place_t;

  logic clk_i;
  logic rst_ni;

  kme_in_if  evt_if ();
  kme_out_if res_if ();

  keyboard_matrix_emulator u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_if),
    .res_o  (res_if)
  );

  key_word_t   words_to_send[$];
  row_word_t   rows_due[$];
  row_t        key_state[NumRows];
  bit          no_gaps;
  int unsigned words_sent;
  int unsigned rows_checked;
  int unsigned known_hits;
  int unsigned error_count;

  // Matrix position of each host code, shift flag for the punctuation keys.
  function automatic key_place_t key_place(input logic [7:0] code);
    key_place_t p;
    p = '0;
    case (code)
      8'd48: p = '{1'b1, 1'b0, 3'd4, 5'h01};
      8'd49: p = '{1'b1, 1'b0, 3'd3, 5'h01};
      8'd50: p = '{1'b1, 1'b0, 3'd3, 5'h02};
      8'd51: p = '{1'b1, 1'b0, 3'd3, 5'h04};
      8'd52: p = '{1'b1, 1'b0, 3'd3, 5'h08};
      8'd53: p = '{1'b1, 1'b0, 3'd3, 5'h10};
      8'd54: p = '{1'b1, 1'b0, 3'd4, 5'h10};
      8'd55: p = '{1'b1, 1'b0, 3'd4, 5'h08};
      8'd56: p = '{1'b1, 1'b0, 3'd4, 5'h04};
      8'd57: p = '{1'b1, 1'b0, 3'd4, 5'h02};
      8'd65: p = '{1'b1, 1'b0, 3'd1, 5'h01};
      8'd66: p = '{1'b1, 1'b0, 3'd7, 5'h10};
      8'd67: p = '{1'b1, 1'b0, 3'd0, 5'h08};
      8'd68: p = '{1'b1, 1'b0, 3'd1, 5'h04};
      8'd69: p = '{1'b1, 1'b0, 3'd2, 5'h04};
      8'd70: p = '{1'b1, 1'b0, 3'd1, 5'h08};
      8'd71: p = '{1'b1, 1'b0, 3'd1, 5'h10};
      8'd72: p = '{1'b1, 1'b0, 3'd6, 5'h10};
      8'd73: p = '{1'b1, 1'b0, 3'd5, 5'h04};
      8'd74: p = '{1'b1, 1'b0, 3'd6, 5'h08};
      8'd75: p = '{1'b1, 1'b0, 3'd6, 5'h04};
      8'd76: p = '{1'b1, 1'b0, 3'd6, 5'h02};
      8'd77: p = '{1'b1, 1'b0, 3'd7, 5'h04};
      8'd78: p = '{1'b1, 1'b0, 3'd7, 5'h08};
      8'd79: p = '{1'b1, 1'b0, 3'd5, 5'h02};
      8'd80: p = '{1'b1, 1'b0, 3'd5, 5'h01};
      8'd81: p = '{1'b1, 1'b0, 3'd2, 5'h01};
      8'd82: p = '{1'b1, 1'b0, 3'd2, 5'h08};
      8'd83: p = '{1'b1, 1'b0, 3'd1, 5'h02};
      8'd84: p = '{1'b1, 1'b0, 3'd2, 5'h10};
      8'd85: p = '{1'b1, 1'b0, 3'd5, 5'h08};
      8'd86: p = '{1'b1, 1'b0, 3'd0, 5'h10};
      8'd87: p = '{1'b1, 1'b0, 3'd2, 5'h02};
      8'd88: p = '{1'b1, 1'b0, 3'd0, 5'h04};
      8'd89: p = '{1'b1, 1'b0, 3'd5, 5'h10};
      8'd90: p = '{1'b1, 1'b0, 3'd0, 5'h02};
      8'd32: p = '{1'b1, 1'b0, 3'd7, 5'h01};
      8'd13: p = '{1'b1, 1'b0, 3'd6, 5'h01};
      8'd44: p = '{1'b1, 1'b1, 3'd7, 5'h02};
      8'd59: p = '{1'b1, 1'b1, 3'd0, 5'h04};
      8'd45: p = '{1'b1, 1'b1, 3'd6, 5'h08};
      8'd61: p = '{1'b1, 1'b1, 3'd6, 5'h02};
      8'd47: p = '{1'b1, 1'b1, 3'd0, 5'h10};
      default: p = '0;
    endcase
    return p;
  endfunction

  // Applies one word to the local matrix and returns the row word it yields.
  function automatic row_word_t apply_key_word(input key_word_t w);
    key_place_t p;
    row_word_t  r;
    bit         down;
    p      = key_place(w.keycode);
    down   = (w.action == ACT_PRESS);
    r.key_known = 1'b0;
    if ((w.action == ACT_PRESS || w.action == ACT_RELEASE) && p.hit) begin
      r.key_known = 1'b1;
      // A shifted key moves shift too, whatever else holds it.
      if (p.with_shift) begin
        if (down) key_state[SHIFT_ROW] = key_state[SHIFT_ROW] & ~SHIFT_MASK;
        else      key_state[SHIFT_ROW] = key_state[SHIFT_ROW] | SHIFT_MASK;
      end
      if (down) key_state[p.row] = key_state[p.row] & ~p.mask;
      else      key_state[p.row] = key_state[p.row] | p.mask;
    end
    if (w.row_select < NumRows) r.row_bits = {ROW_PAD, key_state[w.row_select[RowIdxW-1:0]]};
    else                        r.row_bits = ROW_NONE;
    return r;
  endfunction

  function automatic key_word_t make_word(input logic [1:0] action, input logic [7:0] code,
                                          input logic [3:0] sel);
    key_word_t w;
    w.action     = action;
    w.keycode    = code;
    w.row_select = sel;
    return w;
  endfunction

  // Random word: mostly presses and releases of real keys, some reads and noise.
  function automatic key_word_t random_word();
    key_word_t   w;
    key_place_t  p;
    int unsigned pick;
    logic [7:0]  code;
    pick = $urandom_range(0, 99);
    w.keycode    = 8'($urandom_range(0, 255));
    w.row_select = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(8, 15))
                                               : 4'($urandom_range(0, 7));
    if (pick < 70) begin
      code = 8'($urandom_range(13, 90));
      p    = key_place(code);
      while (!p.hit) begin
        code = 8'($urandom_range(13, 90));
        p    = key_place(code);
      end
      w.keycode = code;
      w.action  = (pick < 40) ? ACT_PRESS : ACT_RELEASE;
    end else if (pick < 88) begin
      w.action = ACT_READ;
    end else if (pick < 95) begin
      w.action = ($urandom_range(0, 1) == 0) ? ACT_PRESS : ACT_RELEASE;
    end else begin
      w.action = ACT_UNUSED;
    end
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < MaxPrints) $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Holds the caller until every queued word went out and its row came back.
  task automatic wait_drained();
    while (words_to_send.size() != 0 || evt_if.valid || rows_due.size() != 0)
      @(posedge clk_i);
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Known values on every input from time zero.
  initial begin
    rst_ni             = 1'b0;
    evt_if.valid       = 1'b0;
    evt_if.action      = ACT_READ;
    evt_if.keycode     = 8'd0;
    evt_if.row_select  = 4'd0;
    res_if.ready       = 1'b0;
    no_gaps            = 1'b0;
    words_sent         = 0;
    rows_checked       = 0;
    known_hits         = 0;
    error_count        = 0;
    for (int r = 0; r < NumRows; r++) key_state[r] = ROW_RELEASED;
  end

  // Word driver: records each accepted word, then offers the next one.
  always @(posedge clk_i) begin
    key_word_t w;
    row_word_t r;
    if (!rst_ni) begin
      evt_if.valid <= 1'b0;
    end else begin
      if (evt_if.valid && evt_if.ready) begin
        r = apply_key_word(make_word(evt_if.action, evt_if.keycode, evt_if.row_select));
        rows_due.push_back(r);
        words_sent++;
        if (r.key_known) known_hits++;
      end
      if (!evt_if.valid || evt_if.ready) begin
        if (words_to_send.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 24)) begin
          w = words_to_send.pop_front();
          evt_if.valid      <= 1'b1;
          evt_if.action     <= w.action;
          evt_if.keycode    <= w.keycode;
          evt_if.row_select <= w.row_select;
        end else begin
          evt_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result ready: random gaps plus one long stall that backs up the block.
  int unsigned stall_left;
  bit          stall_done;
  initial begin
    stall_left = 0;
    stall_done = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      res_if.ready <= 1'b0;
    end else if (!stall_done && rows_checked >= StallAfter) begin
      stall_done = 1'b1;
      stall_left = StallCycles - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= no_gaps || ($urandom_range(0, 99) >= 24);
    end
  end

  // Row monitor: each returned word against the oldest prediction.
  always @(posedge clk_i) begin
    row_word_t r;
    if (rst_ni && res_if.valid && res_if.ready) begin
      rows_checked++;
      if (rows_due.size() == 0) begin
        report_mismatch($sformatf("row word 0x%02h with nothing outstanding", res_if.row_bits));
      end else begin
        r = rows_due.pop_front();
        if (res_if.row_bits !== r.row_bits)
          report_mismatch($sformatf("row_bits 0x%02h, want 0x%02h",
                                    res_if.row_bits, r.row_bits));
        if (res_if.key_known !== r.key_known)
          report_mismatch($sformatf("key_known %b, want %b",
                                    res_if.key_known, r.key_known));
      end
    end
  end

  // Watchdog on cycles with no traffic on either channel.
  int unsigned quiet_cycles;
  initial quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready) || !rst_ni) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("Timeout: no traffic for %0d cycles", IdleLimit);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset state, the field extremes, reads and presses.
    words_to_send.push_back(make_word(ACT_READ,    8'd0,   4'd0));
    words_to_send.push_back(make_word(ACT_READ,    8'd255, 4'd15));
    words_to_send.push_back(make_word(ACT_PRESS,   8'd65,  4'd1));
    words_to_send.push_back(make_word(ACT_PRESS,   8'd90,  4'd0));
    // Two shifted keys share shift; releasing one lets shift go.
    words_to_send.push_back(make_word(ACT_PRESS,   8'd44,  4'd7));
    words_to_send.push_back(make_word(ACT_PRESS,   8'd59,  4'd0));
    words_to_send.push_back(make_word(ACT_RELEASE, 8'd44,  4'd0));
    words_to_send.push_back(make_word(ACT_RELEASE, 8'd59,  4'd0));
    words_to_send.push_back(make_word(ACT_PRESS,   8'd45,  4'd6));
    words_to_send.push_back(make_word(ACT_PRESS,   8'd61,  4'd6));
    words_to_send.push_back(make_word(ACT_RELEASE, 8'd45,  4'd6));
    words_to_send.push_back(make_word(ACT_RELEASE, 8'd61,  4'd0));
    words_to_send.push_back(make_word(ACT_PRESS,   8'd47,  4'd0));
    words_to_send.push_back(make_word(ACT_RELEASE, 8'd47,  4'd0));
    // Codes outside the table leave the matrix alone.
    words_to_send.push_back(make_word(ACT_PRESS,   8'd0,   4'd8));
    words_to_send.push_back(make_word(ACT_RELEASE, 8'd255, 4'd15));
    words_to_send.push_back(make_word(ACT_PRESS,   8'd4,   4'd7));
    // The unused action behaves like a read even with a real key code.
    words_to_send.push_back(make_word(ACT_UNUSED,  8'd65,  4'd1));
    words_to_send.push_back(make_word(ACT_PRESS,   8'd13,  4'd6));
    words_to_send.push_back(make_word(ACT_PRESS,   8'd32,  4'd7));
    words_to_send.push_back(make_word(ACT_PRESS,   8'd48,  4'd4));
    words_to_send.push_back(make_word(ACT_PRESS,   8'd57,  4'd4));
    words_to_send.push_back(make_word(ACT_RELEASE, 8'd65,  4'd1));
    words_to_send.push_back(make_word(ACT_RELEASE, 8'd90,  4'd0));
    words_to_send.push_back(make_word(ACT_READ,    8'd255, 4'd9));
    wait_drained();

    // Random traffic with gaps; the long output stall falls in here.
    for (int i = 0; i < 350; i++) words_to_send.push_back(random_word());
    wait_drained();

    // A stretch with both sides running flat out.
    no_gaps = 1'b1;
    for (int i = 0; i < 250; i++) words_to_send.push_back(random_word());
    wait_drained();
    no_gaps = 1'b0;

    for (int i = 0; i < 320; i++) words_to_send.push_back(random_word());
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d key words (%0d hit the key table), checked %0d row words.",
             words_sent, known_hits, rows_checked);
    $display("Traffic included random gaps, a flat-out stretch and a %0d-cycle stall.",
             StallCycles);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", error_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
